[rtl/six_bit_frame_encoder_core_macros.svh]
// Assertion helpers for the encoder modules, used by the queue.
`ifndef SIX_BIT_FRAME_ENCODER_CORE_MACROS_SVH
`define SIX_BIT_FRAME_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define SBFE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside of reset.
`define SBFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/sbfe_pkg.sv]
`default_nettype none
package sbfe_pkg;

   localparam int LEN_WIDTH_DEFAULT = 12;
   localparam int MAX_LEN_RESET     = 68;

   // Results one item can cause: start, two data characters, end.
   localparam int RES_MAX   = 4;
   localparam int RES_IDX_W = $clog2(RES_MAX);
   localparam int RES_CNT_W = $clog2(RES_MAX + 1);

   localparam int QUEUE_DEPTH = 2;

   localparam logic [6:0] CH_START = 7'h09;
   localparam logic [6:0] CH_END   = 7'h0a;
   localparam logic [6:0] CH_BASE  = 7'h40;
   localparam logic [6:0] CH_NONE  = 7'h00;

   typedef struct packed {
      logic [6:0] ch;
      logic       fe;
      logic       ov;
   } result_type;

   typedef struct packed {
      logic [RES_CNT_W-1:0]         count;
      result_type [RES_MAX-1:0]     res;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } q_wr_type;

   typedef struct packed {
      logic      empty;
      logic      full;
      entry_type entry;
   } q_rd_type;

endpackage
`default_nettype wire

[rtl/sbfe_front.sv]
`default_nettype none
module sbfe_front #(
   parameter int LEN_WIDTH = sbfe_pkg::LEN_WIDTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [7:0]           req_data,
   input  wire logic                 req_last,
   input  wire logic [LEN_WIDTH-1:0] max_len,
   input  wire sbfe_pkg::q_rd_type   q_status,
   output sbfe_pkg::q_wr_type        q_wr
);
   import sbfe_pkg::*;

   logic [15:0]          acc_ff, acc_in;
   logic [4:0]           held_ff, held_in;
   logic                 in_frame_ff, in_frame_in;
   logic [LEN_WIDTH-1:0] chars_ff, chars_in;
   logic                 dropping_ff, dropping_in;

   logic                 accept;
   entry_type            entry;
   logic [RES_CNT_W-1:0] n;
   logic                 done;
   logic [LEN_WIDTH-1:0] c;
   logic [15:0]          a;
   logic [4:0]           h;
   logic [3:0]           shift;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      acc_in      = acc_ff;
      held_in     = held_ff;
      in_frame_in = in_frame_ff;
      chars_in    = chars_ff;
      dropping_in = dropping_ff;
      entry       = '0;
      n           = '0;
      done        = 1'b0;
      c           = chars_ff;
      a           = acc_ff;
      h           = held_ff;
      shift       = 4'd0;
      if (dropping_ff) begin
         if (req_last) begin
            dropping_in = 1'b0;
         end
      end else begin
         if (!in_frame_ff) begin
            entry.res[n[RES_IDX_W-1:0]] = '{ch: CH_START, fe: 1'b0, ov: 1'b0};
            n = n + 1'b1;
            c = LEN_WIDTH'(1);
            a = '0;
            h = '0;
         end
         shift = (h <= 5'd8) ? 4'(5'd8 - h) : 4'd0;
         a = a | (16'(req_data) << shift);
         h = h + 5'd8 + (req_last ? 5'd4 : 5'd0);
         // At most two whole groups are pending once the byte is merged in.
         for (int k = 0; k < 2; k++) begin
            if (!done && h >= 5'd6) begin
               if (({1'b0, c} + 1'b1) >= {1'b0, max_len}) begin
                  entry.res[n[RES_IDX_W-1:0]] = '{ch: CH_NONE, fe: 1'b1, ov: 1'b1};
                  n = n + 1'b1;
                  done = 1'b1;
                  dropping_in = !req_last;
               end else begin
                  entry.res[n[RES_IDX_W-1:0]] =
                     '{ch: CH_BASE | 7'(a[15:10]), fe: 1'b0, ov: 1'b0};
                  n = n + 1'b1;
                  c = c + 1'b1;
                  a = a << 6;
                  h = h - 5'd6;
               end
            end
         end
         if (!done && req_last) begin
            if (({1'b0, c} + 1'b1) >= {1'b0, max_len}) begin
               entry.res[n[RES_IDX_W-1:0]] = '{ch: CH_NONE, fe: 1'b1, ov: 1'b1};
            end else begin
               entry.res[n[RES_IDX_W-1:0]] = '{ch: CH_END, fe: 1'b1, ov: 1'b0};
            end
            n = n + 1'b1;
         end
         if (done || req_last) begin
            acc_in      = '0;
            held_in     = '0;
            in_frame_in = 1'b0;
            chars_in    = '0;
         end else begin
            acc_in      = a;
            held_in     = h;
            in_frame_in = 1'b1;
            chars_in    = c;
         end
      end
      entry.count = n;
   end

   assign q_wr.push  = accept && (entry.count != '0);
   assign q_wr.entry = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         held_ff     <= '0;
         in_frame_ff <= 1'b0;
         chars_ff    <= '0;
         dropping_ff <= 1'b0;
      end else if (accept) begin
         acc_ff      <= acc_in;
         held_ff     <= held_in;
         in_frame_ff <= in_frame_in;
         chars_ff    <= chars_in;
         dropping_ff <= dropping_in;
      end
   end

endmodule
`default_nettype wire

[rtl/sbfe_queue.sv]
`default_nettype none
`include "six_bit_frame_encoder_core_macros.svh"
module sbfe_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sbfe_pkg::q_wr_type q_wr,
   input  wire logic               pop,
   output sbfe_pkg::q_rd_type      q_rd
);
   import sbfe_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign q_rd.empty = (count_ff == '0);
   assign q_rd.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_rd.entry = mem_ff[rd_ptr_ff];

   assign do_push = q_wr.push && !q_rd.full;
   assign do_pop  = pop && !q_rd.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= q_wr.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `SBFE_ASSERT_NOW(a_push_not_full, clock, reset, q_wr.push, !q_rd.full, "push into full queue")
   `SBFE_ASSERT_NOW(a_pop_not_empty, clock, reset, pop, !q_rd.empty, "pop from empty queue")
   `SBFE_ASSERT_NEXT(a_push_grows, clock, reset, do_push && !do_pop,
      count_ff == $past(count_ff) + 1'b1, "queue count did not grow on push")
   `SBFE_ASSERT_NOW(a_empty_entry, clock, reset, q_wr.push, q_wr.entry.count != '0,
      "queued item carries no results")

endmodule
`default_nettype wire

[rtl/sbfe_back.sv]
`default_nettype none
module sbfe_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sbfe_pkg::q_rd_type q_rd,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [6:0]              rsp_char,
   output logic                    rsp_frame_end,
   output logic                    rsp_overflow
);
   import sbfe_pkg::*;

   entry_type            cur_ff;
   logic                 valid_ff;
   logic [RES_IDX_W-1:0] idx_ff;
   logic                 sent;
   logic                 last_of_entry;
   logic                 load;
   result_type           res;

   assign res           = cur_ff.res[idx_ff];
   assign rsp_tvalid    = valid_ff;
   assign rsp_char      = res.ch;
   assign rsp_frame_end = res.fe;
   assign rsp_overflow  = res.ov;

   assign sent          = valid_ff && rsp_tready;
   assign last_of_entry = ({1'b0, idx_ff} + 1'b1) == cur_ff.count;
   // The next queued item moves in the same cycle its predecessor's final result leaves.
   assign load          = !valid_ff || (sent && last_of_entry);
   assign pop           = load && !q_rd.empty;

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= q_rd.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= !q_rd.empty;
         idx_ff   <= '0;
      end else if (sent) begin
         idx_ff   <= idx_ff + 1'b1;
      end
   end

endmodule
`default_nettype wire

[rtl/six_bit_frame_encoder_core.sv]
// Six-bit frame encoder.
// req channel: one payload byte per item, req_tdata[7:0] the byte, req_tlast
// marks the final byte of a frame. rsp channel: one character per item,
// rsp_tdata[6:0] the character (0x09 start, 0x40..0x7f data, 0x0a end, 0 on
// overflow), rsp_tlast on the closing character, rsp_tuser on overflow.
// csr_wr_en writes csr_wr_data as the maximum frame length.
// Each byte gives up to four characters, none while a frame is being dropped.
// The front accepts a byte per cycle while its two-entry queue has room; the
// back sends one character per cycle while rsp_tready is high, so the
// character rate of one per cycle sets throughput (about 4/3 characters per
// byte inside a frame, up to four at frame edges).
// The first character of a byte passes through its queue entry and then the
// back's current-item register before it is valid.
// Reset clears the frame state, the queue and the output, and restores the
// maximum length to 68; no clearing pass is needed.
// When the receiver stalls, the current character holds and the queue fills;
// req_tready drops once both queue entries are taken.
`default_nettype none
module six_bit_frame_encoder_core #(
   parameter int LEN_WIDTH = sbfe_pkg::LEN_WIDTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [7:0]           req_tdata,   // [7:0] data_byte
   input  wire logic                 req_tlast,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [7:0]                rsp_tdata,   // [6:0] out_char, [7] zero
   output logic                      rsp_tlast,
   output logic                      rsp_tuser,   // [0] overflow
   input  wire logic                 csr_wr_en,
   input  wire logic [LEN_WIDTH-1:0] csr_wr_data
);
   import sbfe_pkg::*;

   logic [LEN_WIDTH-1:0] max_len_ff;
   q_wr_type             q_wr;
   q_rd_type             q_rd;
   logic                 pop;
   logic [6:0]           rsp_char;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= LEN_WIDTH'(MAX_LEN_RESET);
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   sbfe_front #(.LEN_WIDTH(LEN_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_data   (req_tdata),
      .req_last   (req_tlast),
      .max_len    (max_len_ff),
      .q_status   (q_rd),
      .q_wr       (q_wr)
   );

   sbfe_queue u_queue (
      .clock (clock),
      .reset (reset),
      .q_wr  (q_wr),
      .pop   (pop),
      .q_rd  (q_rd)
   );

   sbfe_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_rd          (q_rd),
      .pop           (pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_char      (rsp_char),
      .rsp_frame_end (rsp_tlast),
      .rsp_overflow  (rsp_tuser)
   );

   assign rsp_tdata = {1'b0, rsp_char};

endmodule
`default_nettype wire
